// ===== rtl/core/at_command_line_parser_macros.svh =====
// Assertion macros for the AT command line parser.
`ifndef AT_COMMAND_LINE_PARSER_MACROS_SVH
`define AT_COMMAND_LINE_PARSER_MACROS_SVH

`ifndef SYNTH
`define ACLP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aclp assertion failed");
`define ACLP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aclp assertion failed");
`else
`define ACLP_ASSERT_IMP(label, ante, cons)
`define ACLP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/aclp_pkg.sv =====
// Shared constants, codes and the request token of the AT command line parser.
`default_nettype none
package aclp_pkg;

	localparam int BUFFER_SIZE = 128;
	localparam int NUM_ENTRIES = 16;
	localparam int NAME_LEN    = 16;

	localparam int CFG_W = 5;
	localparam int IDX_W = 4;
	localparam int POS_W = $clog2(NAME_LEN);
	localparam int LEN_W = $clog2(NAME_LEN + 2);
	localparam int CNT_W = $clog2(BUFFER_SIZE + 1);
	localparam int OFF_W = 8;
	localparam int IN_W  = 16;
	localparam int OUT_W = 24;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_EQ = 8'h3d;
	localparam logic [7:0] CH_QM = 8'h3f;

	localparam logic [2:0] ST_MATCH   = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_PREFIX  = 3'd2;
	localparam logic [2:0] ST_CHAR    = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;

	localparam logic [1:0] TY_RUN   = 2'd0;
	localparam logic [1:0] TY_READ  = 2'd1;
	localparam logic [1:0] TY_TEST  = 2'd2;
	localparam logic [1:0] TY_WRITE = 2'd3;

	typedef enum logic [1:0] {
		TK_NONE,
		TK_WRITE,
		TK_CHAR,
		TK_FINISH
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t        kind;
		logic [7:0]       data;
		logic [IDX_W-1:0] entry;
		logic [POS_W-1:0] pos;
		logic             wr_ok;
		logic [2:0]       pre_status;
		logic             try_match;
		logic [1:0]       ctype;
		logic             name_ok;
		logic             chk_zero;
		logic [OFF_W-1:0] offset;
		logic             found;
		logic [IDX_W-1:0] match;
	} tok_t;

endpackage
`default_nettype wire

// ===== rtl/core/aclp_front.sv =====
// Line tracker: collects bytes into lines and issues tokens to the cell chain.
`default_nettype none
module aclp_front
	import aclp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_accept,
	input  wire logic             in_cmd,
	input  wire logic [7:0]       in_byte,
	input  wire logic [IDX_W-1:0] in_entry,
	input  wire logic [3:0]       in_pos,
	output tok_t                  tok_out
);

	typedef enum logic [2:0] {
		PH_EXPECT_A,
		PH_EXPECT_T,
		PH_NAME,
		PH_AFTER_EQ,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_PREFIX,
		ERR_CHAR
	} err_t;

	phase_t           phase_q, phase_d;
	err_t             err_q, err_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] eq_q, eq_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [1:0]       type_q, type_d;
	logic             term_q, term_d;
	tok_t             tok_q, tok_d;

	function automatic logic legal_char(input logic [7:0] c);
		legal_char = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h30 && c <= 8'h39) ||
			c == 8'h2b || c == 8'h23 || c == 8'h24 || c == 8'h40 || c == 8'h5f ||
			c == CH_EQ || c == CH_QM;
	endfunction

	always_comb begin
		phase_d = phase_q;
		err_d   = err_q;
		cnt_d   = cnt_q;
		eq_d    = eq_q;
		len_d   = len_q;
		type_d  = type_q;
		term_d  = term_q;
		tok_d   = '0;
		tok_d.kind = TK_NONE;
		if (in_accept) begin
			if (in_cmd) begin
				tok_d.kind  = TK_WRITE;
				tok_d.data  = in_byte;
				tok_d.entry = in_entry;
				tok_d.pos   = POS_W'(in_pos);
				tok_d.wr_ok = LEN_W'(in_pos) < LEN_W'(NAME_LEN);
			end else if (in_byte != 8'd0 && !in_byte[7]) begin
				if (in_byte != CH_CR && in_byte != CH_LF && cnt_q < CNT_W'(BUFFER_SIZE)) begin
					cnt_d = cnt_q + CNT_W'(1);
					if (err_q == ERR_NONE) begin
						unique case (phase_q)
							PH_EXPECT_A: begin
								if (in_byte == CH_A) phase_d = PH_EXPECT_T;
								else err_d = ERR_PREFIX;
							end
							PH_EXPECT_T: begin
								if (in_byte == CH_T) phase_d = PH_NAME;
								else err_d = ERR_PREFIX;
							end
							PH_NAME: begin
								if (!legal_char(in_byte)) begin
									err_d = ERR_CHAR;
								end else if (in_byte == CH_EQ) begin
									eq_d    = cnt_q;
									phase_d = PH_AFTER_EQ;
								end else if (in_byte == CH_QM) begin
									type_d  = TY_READ;
									phase_d = PH_DONE;
								end else begin
									if (len_q < LEN_W'(NAME_LEN)) begin
										tok_d.kind = TK_CHAR;
										tok_d.data = in_byte;
										tok_d.pos  = len_q[POS_W-1:0];
									end
									if (len_q <= LEN_W'(NAME_LEN)) len_d = len_q + LEN_W'(1);
								end
							end
							PH_AFTER_EQ: begin
								type_d  = (in_byte == CH_QM) ? TY_TEST : TY_WRITE;
								phase_d = PH_DONE;
							end
							PH_DONE: begin
							end
						endcase
					end
				end
				if (!term_q) begin
					if (in_byte == CH_CR) term_d = 1'b1;
				end else if (in_byte != CH_LF) begin
					term_d = 1'b0;
				end else begin
					tok_d.kind     = TK_FINISH;
					tok_d.name_ok  = len_q <= LEN_W'(NAME_LEN);
					tok_d.chk_zero = len_q < LEN_W'(NAME_LEN);
					tok_d.pos      = len_q[POS_W-1:0];
					tok_d.offset   = OFF_W'(eq_q) + OFF_W'(1);
					if (cnt_q == '0) begin
						tok_d.pre_status = ST_EMPTY;
					end else if (err_q == ERR_PREFIX || phase_q == PH_EXPECT_A ||
						phase_q == PH_EXPECT_T) begin
						tok_d.pre_status = ST_PREFIX;
					end else if (err_q == ERR_CHAR) begin
						tok_d.pre_status = ST_CHAR;
					end else begin
						tok_d.pre_status = ST_UNKNOWN;
						tok_d.try_match  = 1'b1;
						if (phase_q == PH_AFTER_EQ) tok_d.ctype = TY_WRITE;
						else if (phase_q == PH_DONE) tok_d.ctype = type_q;
						else tok_d.ctype = TY_RUN;
					end
					phase_d = PH_EXPECT_A;
					err_d   = ERR_NONE;
					cnt_d   = '0;
					eq_d    = '0;
					len_d   = '0;
					type_d  = TY_RUN;
					term_d  = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_EXPECT_A;
			err_q   <= ERR_NONE;
			cnt_q   <= '0;
			eq_q    <= '0;
			len_q   <= '0;
			type_q  <= TY_RUN;
			term_q  <= 1'b0;
			tok_q   <= '0;
		end else begin
			phase_q <= phase_d;
			err_q   <= err_d;
			cnt_q   <= cnt_d;
			eq_q    <= eq_d;
			len_q   <= len_d;
			type_q  <= type_d;
			term_q  <= term_d;
			if (adv) tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

// ===== rtl/core/aclp_cell.sv =====
// Matching cell: one table entry, its alive bit and one token stage.
`default_nettype none
module aclp_cell
	import aclp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [CFG_W-1:0] cmd_count,
	input  wire tok_t             tok_in,
	output tok_t                  tok_out
);

	logic [7:0] row_q [NAME_LEN];
	logic       alive_q;
	tok_t       tok_q;
	tok_t       tok_nxt;
	logic [7:0] rd_char;
	logic       hit;

	assign rd_char = row_q[tok_in.pos];
	assign hit = tok_in.try_match && tok_in.name_ok && !tok_in.found && alive_q &&
		(CFG_W'(idx) < cmd_count) && (!tok_in.chk_zero || rd_char == 8'd0);

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.kind == TK_FINISH && hit) begin
			tok_nxt.found = 1'b1;
			tok_nxt.match = idx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_in.kind == TK_WRITE && tok_in.entry == idx && tok_in.wr_ok) begin
			row_q[tok_in.pos] <= tok_in.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b1;
			tok_q   <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
			case (tok_in.kind)
				TK_CHAR: begin
					if (rd_char != tok_in.data) alive_q <= 1'b0;
				end
				TK_FINISH: begin
					alive_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

// ===== rtl/core/at_command_line_parser.sv =====
// AT command line parser: one result per CR LF terminated line.
// Each LF request passes the front stage, the entry cells and the output register before its result appears.
// Throughput: one request per cycle through a front stage and a chain of one cell per entry.
// Intake holds only while a finished result sits at the chain end and the output is held.
// Reset clears line state and the entry count and sets all alive bits; table contents stay undefined.
`default_nettype none
`include "at_command_line_parser_macros.svh"
module at_command_line_parser
	import aclp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output      logic             cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data,      // command_count
	input  wire logic             s_axis_tvalid,
	output      logic             s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,  // byte_value, entry_index, char_position
	input  wire logic             s_axis_tuser,  // command
	output      logic             m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output      logic [OUT_W-1:0] m_axis_tdata   // status, command_type, matched_entry,
	                                             // param_offset, zero pad
);

	logic             cfg_write;
	logic [CFG_W-1:0] cmd_count_q;
	logic             adv;
	logic             in_accept;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	tok_t             chain [NUM_ENTRIES+1];
	tok_t             tail;
	logic [2:0]       res_status;
	logic [IDX_W-1:0] res_entry;
	logic [OFF_W-1:0] res_offset;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmd_count_q <= '0;
		else if (cfg_write) cmd_count_q <= cfg_data;
	end

	assign tail          = chain[NUM_ENTRIES];
	assign adv           = !(tail.kind == TK_FINISH && out_valid_q && !m_axis_tready);
	assign s_axis_tready = adv;
	assign in_accept     = s_axis_tvalid && adv;

	aclp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_accept (in_accept),
		.in_cmd    (s_axis_tuser),
		.in_byte   (s_axis_tdata[7:0]),
		.in_entry  (s_axis_tdata[11:8]),
		.in_pos    (s_axis_tdata[15:12]),
		.tok_out   (chain[0])
	);

	for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
		aclp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.idx       (IDX_W'(g)),
			.cmd_count (cmd_count_q),
			.tok_in    (chain[g]),
			.tok_out   (chain[g+1])
		);
	end

	always_comb begin
		res_status = tail.pre_status;
		res_entry  = '0;
		res_offset = '0;
		if (tail.try_match) begin
			res_status = tail.found ? ST_MATCH : ST_UNKNOWN;
			if (tail.found) begin
				res_entry = tail.match;
				if (tail.ctype == TY_WRITE) res_offset = tail.offset;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (adv && tail.kind == TK_FINISH) begin
			out_valid_q <= 1'b1;
			out_data_q  <= {7'd0, res_offset, res_entry, tail.ctype, res_status};
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`ACLP_ASSERT_IMP(a_stall_cause, !s_axis_tready, tail.kind == TK_FINISH && m_axis_tvalid)
	`ACLP_ASSERT_NEXT(a_finish_lands, adv && tail.kind == TK_FINISH, m_axis_tvalid)
	`ACLP_ASSERT_NEXT(a_held_result, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`ACLP_ASSERT_IMP(a_match_status, tail.found, tail.try_match)

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the AT command line parser: directed and random lines.
`default_nettype none
module tb_top;
	import aclp_pkg::*;

	typedef enum logic [2:0] {
		LP_WANT_A,
		LP_WANT_T,
		LP_NAME,
		LP_AFTER_EQ,
		LP_TYPED
	} line_phase_t;

	typedef enum logic [1:0] {
		LE_NONE,
		LE_PREFIX,
		LE_CHAR
	} line_err_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [1:0]       ctype;
		logic [IDX_W-1:0] entry;
		logic [OFF_W-1:0] offset;
	} at_reply_t;

	localparam int DRAIN_CYCLES = NUM_ENTRIES + 8;
	localparam int RANDOM_ITEMS = 750;
	localparam int COUNT_PHASES = 7;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             cfg_valid     = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data      = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata  = '0;   // byte_value, entry_index, char_position
	logic             s_axis_tuser  = 1'b0; // command
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b1;
	logic [OUT_W-1:0] m_axis_tdata;         // status, command_type, matched_entry,
	                                        // param_offset, zero pad

	string NAME_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+#$@_";
	string BAD_CHARS  = "abcxyz ,.;:!-*/&%";

	logic [7:0]             name_tbl [NUM_ENTRIES][NAME_LEN];
	logic [CFG_W-1:0]       entry_count;
	line_phase_t            phase;
	line_err_t              line_err;
	bit                     cr_pending;
	int                     buf_fill;
	int                     name_len;
	int                     eq_at;
	logic [NUM_ENTRIES-1:0] alive;
	logic [1:0]             found_ty;

	at_reply_t  expected_replies [$];
	logic [7:0] line_q [$];
	int         err_count   = 0;
	int         item_count  = 0;
	int         rx_hold     = 0;
	bit         tx_idle_en  = 1'b0;
	bit         rx_stall_en = 1'b0;

	at_command_line_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic void clear_line();
		phase      = LP_WANT_A;
		line_err   = LE_NONE;
		cr_pending = 1'b0;
		buf_fill   = 0;
		name_len   = 0;
		eq_at      = 0;
		alive      = '1;
		found_ty   = TY_RUN;
	endfunction

	function automatic bit is_name_char(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == "+" || c == "#" ||
			c == "$" || c == "@" || c == "_" || c == CH_EQ || c == CH_QM;
	endfunction

	function automatic void match_name_char(logic [7:0] c);
		if (name_len >= NAME_LEN) begin
			alive = '0;
		end else begin
			for (int e = 0; e < NUM_ENTRIES; e++)
				if (name_tbl[e][name_len] != c) alive[e] = 1'b0;
		end
		if (name_len <= NAME_LEN) name_len++;
	endfunction

	function automatic void parse_char(logic [7:0] c, int pos);
		if (line_err != LE_NONE) return;
		case (phase)
		LP_WANT_A: begin
			if (c == CH_A) phase = LP_WANT_T;
			else line_err = LE_PREFIX;
		end
		LP_WANT_T: begin
			if (c == CH_T) phase = LP_NAME;
			else line_err = LE_PREFIX;
		end
		LP_NAME: begin
			if (!is_name_char(c)) begin
				line_err = LE_CHAR;
			end else if (c == CH_EQ) begin
				eq_at = pos;
				phase = LP_AFTER_EQ;
			end else if (c == CH_QM) begin
				found_ty = TY_READ;
				phase    = LP_TYPED;
			end else begin
				match_name_char(c);
			end
		end
		LP_AFTER_EQ: begin
			found_ty = (c == CH_QM) ? TY_TEST : TY_WRITE;
			phase    = LP_TYPED;
		end
		default: ;
		endcase
	endfunction

	function automatic at_reply_t close_line();
		at_reply_t r;
		int        lim;
		bit        ok;
		r   = '0;
		lim = (int'(entry_count) > NUM_ENTRIES) ? NUM_ENTRIES : int'(entry_count);
		if (buf_fill == 0) begin
			r.status = ST_EMPTY;
		end else if (line_err == LE_PREFIX || phase == LP_WANT_A || phase == LP_WANT_T) begin
			r.status = ST_PREFIX;
		end else if (line_err == LE_CHAR) begin
			r.status = ST_CHAR;
		end else begin
			if (phase == LP_AFTER_EQ) r.ctype = TY_WRITE;
			else if (phase == LP_TYPED) r.ctype = found_ty;
			else r.ctype = TY_RUN;
			r.status = ST_UNKNOWN;
			if (name_len <= NAME_LEN) begin
				for (int e = 0; e < lim; e++) begin
					ok = alive[e];
					if (ok && name_len < NAME_LEN && name_tbl[e][name_len] != 8'd0) ok = 1'b0;
					if (ok && r.status != ST_MATCH) begin
						r.status = ST_MATCH;
						r.entry  = IDX_W'(e);
					end
				end
			end
			if (r.status == ST_MATCH && r.ctype == TY_WRITE) r.offset = OFF_W'(eq_at + 1);
		end
		return r;
	endfunction

	function automatic void parse_request(bit cmd, logic [7:0] c, logic [3:0] e, logic [3:0] p);
		if (cmd) begin
			if (e < NUM_ENTRIES && p < NAME_LEN) name_tbl[e][p] = c;
			return;
		end
		if (c == 8'd0 || c > 8'd127) return;
		if (c != CH_CR && c != CH_LF && buf_fill < BUFFER_SIZE) begin
			parse_char(c, buf_fill);
			buf_fill++;
		end
		if (!cr_pending) begin
			if (c == CH_CR) cr_pending = 1'b1;
			return;
		end
		if (c != CH_LF) begin
			cr_pending = 1'b0;
			return;
		end
		expected_replies.push_back(close_line());
		clear_line();
	endfunction

	task automatic send_item(bit cmd, logic [7:0] c, logic [3:0] e, logic [3:0] p);
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {p, e, c};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		parse_request(cmd, c, e, p);
		if (cmd || (c != 8'd0 && c < 8'd128)) item_count++;
	endtask

	task automatic send_byte(logic [7:0] c);
		send_item(1'b0, c, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic load_entry(int e, string nm);
		for (int p = 0; p < NAME_LEN; p++)
			send_item(1'b1, (p < nm.len()) ? nm[p] : 8'd0, 4'(e), 4'(p));
	endtask

	task automatic set_entry_count(logic [CFG_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid   <= 1'b0;
		entry_count = v;
	endtask

	function automatic logic [7:0] name_char();
		return NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)];
	endfunction

	function automatic int pick_name_len();
		case ($urandom_range(0, 9))
		0: return 0;
		1: return NAME_LEN;
		default: return $urandom_range(1, 5);
		endcase
	endfunction

	function automatic string fresh_name(int len, bit narrow);
		string s;
		int    k;
		s = "";
		for (int i = 0; i < len; i++) begin
			k = narrow ? $urandom_range(0, 1) : $urandom_range(0, NAME_CHARS.len() - 1);
			s = {s, NAME_CHARS.substr(k, k)};
		end
		return s;
	endfunction

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
	endfunction

	function automatic void push_random_name(int len);
		repeat (len) line_q.push_back(name_char());
	endfunction

	function automatic void push_entry_name(int e);
		for (int p = 0; p < NAME_LEN && name_tbl[e][p] != 8'd0; p++)
			line_q.push_back(name_tbl[e][p]);
	endfunction

	function automatic void push_params(int len);
		repeat (len) line_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
	endfunction

	function automatic logic [7:0] skip_byte();
		return $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(128, 255));
	endfunction

	function automatic void build_good_line();
		int start;
		int nlen;
		int pick;
		push_str("AT");
		start = line_q.size();
		pick  = $urandom_range(0, 9);
		if (pick < 6) begin
			push_entry_name($urandom_range(0, NUM_ENTRIES - 1));
		end else if (pick < 8) begin
			push_entry_name($urandom_range(0, NUM_ENTRIES - 1));
			nlen = line_q.size() - start;
			case ($urandom_range(0, 2))
			0: if (nlen > 0) line_q[start + $urandom_range(0, nlen - 1)] = name_char();
			1: line_q.push_back(name_char());
			default: if (nlen > 0) void'(line_q.pop_back());
			endcase
		end else if (pick == 8) begin
			push_random_name($urandom_range(NAME_LEN + 1, NAME_LEN + 4));
		end else begin
			push_random_name($urandom_range(0, 4));
		end
		case ($urandom_range(0, 3))
		1: line_q.push_back(CH_QM);
		2: push_str("=?");
		3: begin
			line_q.push_back(CH_EQ);
			push_params($urandom_range(0, 8));
		end
		default: ;
		endcase
		push_str("\r\n");
		if ($urandom_range(0, 5) == 0)
			line_q.insert($urandom_range(0, line_q.size() - 1), skip_byte());
	endfunction

	function automatic void build_noise_line();
		int start;
		case ($urandom_range(0, 9))
		0, 1: repeat ($urandom_range(0, 12)) line_q.push_back(8'($urandom_range(1, 127)));
		2, 3: begin
			push_str("AT");
			start = line_q.size();
			push_random_name($urandom_range(1, 4));
			line_q.insert(start + $urandom_range(0, line_q.size() - start),
				BAD_CHARS[$urandom_range(0, BAD_CHARS.len() - 1)]);
			if ($urandom_range(0, 1)) line_q.push_back(CH_QM);
		end
		4: begin
			case ($urandom_range(0, 4))
			0: push_str("A");
			1: push_str("at");
			2: push_str("TA");
			3: push_str("A T");
			default: push_str("ZAT");
			endcase
			push_random_name($urandom_range(0, 3));
		end
		5: ;
		6: begin
			push_str("AT");
			push_random_name($urandom_range(0, 2));
			line_q.push_back(CH_CR);
			line_q.push_back($urandom_range(0, 1) ? CH_CR : name_char());
		end
		7: begin
			push_str("AT");
			push_entry_name($urandom_range(0, NUM_ENTRIES - 1));
			line_q.push_back(CH_QM);
			push_params($urandom_range(1, 6));
		end
		8: begin
			push_str("AT");
			push_entry_name($urandom_range(0, NUM_ENTRIES - 1));
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 1)) line_q.push_back(CH_EQ);
				push_params($urandom_range(BUFFER_SIZE - 8, BUFFER_SIZE + 12));
			end
		end
		default: begin
			push_str("AT");
			push_entry_name($urandom_range(0, NUM_ENTRIES - 1));
			repeat ($urandom_range(1, 4))
				line_q.insert($urandom_range(0, line_q.size()), skip_byte());
		end
		endcase
		push_str("\r\n");
	endfunction

	task automatic send_line();
		int wr_at;
		wr_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, line_q.size()) : -1;
		for (int i = 0; i < line_q.size(); i++) begin
			if (i == wr_at)
				send_item(1'b1, $urandom_range(0, 1) ? name_char() : 8'd0,
					4'($urandom_range(0, NUM_ENTRIES - 1)),
					4'($urandom_range(0, NAME_LEN - 1)));
			send_byte(line_q[i]);
		end
		line_q.delete();
	endtask

	task automatic test_table_load();
		load_entry(0, "Z");
		load_entry(1, "+CSQ");
		load_entry(2, "+CSQ");
		load_entry(3, "ABCDEFGHIJKLMNOP");
		load_entry(4, "");
		for (int e = 5; e < NUM_ENTRIES; e++) load_entry(e, fresh_name(pick_name_len(), 1'b0));
	endtask

	task automatic test_no_entries();
		send_text("AT+CSQ\r\nAT\r\n");
	endtask

	task automatic test_line_types();
		set_entry_count(CFG_W'(NUM_ENTRIES));
		send_text("AT+CSQ\r\nAT+CSQ?\r\nAT+CSQ=?\r\nAT+CSQ=1,ab\r\nAT+CSQ=\r\n");
	endtask

	task automatic test_line_errors();
		send_text("\r\nat\r\nAX\r\nA\r\nAT+c\r\nATZ?abc\r\nAT?\r\n");
	endtask

	task automatic test_name_lengths();
		send_text("AT\r\nATABCDEFGHIJKLMNOP\r\nATABCDEFGHIJKLMNOPQ\r\nATABCDEFGHIJKLMNO\r\n");
	endtask

	task automatic test_terminators();
		send_byte(CH_A);
		send_byte(8'h00);
		send_byte(CH_T);
		send_byte(8'hff);
		send_byte("Z");
		send_byte(8'h80);
		send_byte(CH_CR);
		send_byte(8'h00);
		send_byte(CH_LF);
		send_text("AT\r\r\nZ\r\nATZ\rX\r\n");
	endtask

	task automatic test_full_buffer();
		send_text("ATZ?");
		repeat (BUFFER_SIZE + 6) send_byte("a");
		send_text("\r\nAT");
		repeat (BUFFER_SIZE + 4) send_byte("A");
		send_text("\r\n");
	endtask

	task automatic test_write_mid_line();
		load_entry(5, "QR");
		send_text("ATQ");
		send_item(1'b1, 8'd0, 4'd5, 4'd1);
		send_text("\r\nATQ");
		send_item(1'b1, "R", 4'd5, 4'd1);
		send_text("\r\n");
	endtask

	task automatic test_entry_count();
		set_entry_count(5'd31);
		send_text("AT+CSQ\r\n");
		set_entry_count(5'd1);
		send_text("AT+CSQ\r\nATZ\r\n");
	endtask

	task automatic test_random_lines();
		logic [CFG_W-1:0] counts [COUNT_PHASES];
		int               target;
		int               quiet_from;
		counts[0]  = 5'd31;
		counts[1]  = CFG_W'($urandom_range(1, NUM_ENTRIES - 1));
		counts[2]  = CFG_W'(NUM_ENTRIES);
		counts[3]  = 5'd0;
		counts[4]  = CFG_W'($urandom_range(NUM_ENTRIES + 1, 30));
		counts[5]  = CFG_W'($urandom_range(1, NUM_ENTRIES - 1));
		counts[6]  = CFG_W'(NUM_ENTRIES);
		quiet_from = item_count + RANDOM_ITEMS * 85 / 100;
		for (int ph = 0; ph < COUNT_PHASES; ph++) begin
			set_entry_count(counts[ph]);
			target = item_count + RANDOM_ITEMS / COUNT_PHASES;
			while (item_count < target) begin
				if (item_count >= quiet_from) begin
					tx_idle_en  = 1'b0;
					rx_stall_en = 1'b0;
				end else if ($urandom_range(0, 3) == 0) begin
					tx_idle_en  = $urandom_range(0, 1);
					rx_stall_en = $urandom_range(0, 1);
				end
				case ($urandom_range(0, 29))
				0, 1: load_entry($urandom_range(0, NUM_ENTRIES - 1),
					fresh_name(pick_name_len(), $urandom_range(0, 2) == 0));
				2: send_item(1'b1, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)));
				default: ;
				endcase
				if ($urandom_range(0, 9) < 7) build_good_line();
				else build_noise_line();
				send_line();
			end
		end
	endtask

	always @(posedge clk) begin : rx_pace
		int n;
		if (rx_hold != 0) n = rx_hold - 1;
		else if (rx_stall_en && $urandom_range(0, 5) == 0) n = $urandom_range(1, 12);
		else n = 0;
		rx_hold       <= n;
		m_axis_tready <= (n == 0);
	end

	always @(posedge clk) begin : reply_check
		at_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_replies.size() == 0) begin
				$error("reply with none pending: tdata %h", m_axis_tdata);
				err_count++;
			end else begin
				want = expected_replies.pop_front();
				if (m_axis_tdata[2:0] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
					err_count++;
				end
				if (m_axis_tdata[4:3] !== want.ctype) begin
					$error("command_type: expected %0d, got %0d", want.ctype, m_axis_tdata[4:3]);
					err_count++;
				end
				if (m_axis_tdata[8:5] !== want.entry) begin
					$error("matched_entry: expected %0d, got %0d", want.entry, m_axis_tdata[8:5]);
					err_count++;
				end
				if (m_axis_tdata[16:9] !== want.offset) begin
					$error("param_offset: expected %0d, got %0d", want.offset, m_axis_tdata[16:9]);
					err_count++;
				end
			end
		end
	end

	initial begin
		for (int e = 0; e < NUM_ENTRIES; e++)
			for (int p = 0; p < NAME_LEN; p++) name_tbl[e][p] = 8'd0;
		entry_count = '0;
		clear_line();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		tx_idle_en  = 1'b1;
		rx_stall_en = 1'b1;
		test_no_entries();
		test_line_types();
		test_line_errors();
		test_name_lengths();
		test_terminators();
		test_full_buffer();
		test_write_mid_line();
		test_entry_count();
		test_random_lines();
		tx_idle_en  = 1'b0;
		rx_stall_en = 1'b0;
		s_axis_tvalid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_replies.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
